// ----- design/scsa_pkg.sv -----
// ----------------------------------------------------------------------------
// scsa_pkg
// shared types, class layout constants and helpers for the slot allocator
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int LIMIT_W     = 20;
    localparam int SLOT_W      = 8;
    localparam int CLASS_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int BOUND_W     = 9;

    // request kinds carried on the input tuser bit
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // slots per class, laid out back to back from slot 0
    localparam int CLASS_COUNT [MAX_CLASSES] = '{10, 10, 10, 30, 40, 30, 20, 10};

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [MAX_CLASSES] = '{
        20'd5000, 20'd7000, 20'd10000, 20'd30000,
        20'd50000, 20'd60000, 20'd70000, 20'd102400
    };

    // first slot of class k, clipped at the pool size
    function automatic logic [BOUND_W-1:0] class_base(input int k, input int total);
        int acc;
        acc = 0;
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            if (i < k)
                acc = acc + CLASS_COUNT[i];
        end
        if (acc > total)
            acc = total;
        return BOUND_W'(acc);
    endfunction

    typedef struct packed {
        logic load;     // capture the accepted word
        logic eval;     // register per-class scan results
        logic commit;   // update in-use bits and the result register
    } scsa_cmd_t;

endpackage

// ----- design/scsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// scsa_ctrl
// sequencer for load, scan and commit, owns both stream handshakes
// ----------------------------------------------------------------------------
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output scsa_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- design/scsa_dp.sv -----
// ----------------------------------------------------------------------------
// scsa_dp
// limit registers, in-use bits, per-class free-slot encoders and result regs
// ----------------------------------------------------------------------------
module scsa_dp
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int TOTAL_SLOTS = 160
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scsa_cmd_t            cmd,
    input  logic                 in_mode,
    input  logic [LIMIT_W-1:0]   in_size,
    input  logic [SLOT_W-1:0]    in_slot,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output logic                 out_success,
    output logic [SLOT_W-1:0]    out_slot,
    output logic [CLASS_W-1:0]   out_class
);

    localparam int NC    = NUM_CLASSES;
    localparam int TS    = TOTAL_SLOTS;
    localparam int IDX_W = (TS > 1) ? $clog2(TS) : 1;

    logic [LIMIT_W-1:0] limit_reg [MAX_CLASSES];
    logic [TS-1:0]      in_use_reg;
    logic [TS-1:0]      in_use_next;

    // captured request
    logic               mode_reg;
    logic [LIMIT_W-1:0] size_reg;
    logic [SLOT_W-1:0]  slot_reg;

    // per-class scan results
    logic [NC-1:0]      fit_comb;
    logic [NC-1:0]      any_comb;
    logic [NC-1:0]      hit_comb;
    logic [SLOT_W-1:0]  low_comb [NC];
    logic [NC-1:0]      fit_reg;
    logic [NC-1:0]      any_reg;
    logic [NC-1:0]      hit_reg;
    logic [SLOT_W-1:0]  low_reg [NC];

    // commit selection
    logic               sel_ok;
    logic [SLOT_W-1:0]  sel_slot;
    logic [CLASS_W-1:0] sel_class;

    for (genvar k = 0; k < NC; k++)
    begin : g_class
        localparam logic [BOUND_W-1:0] BASE = class_base(k, TS);
        localparam logic [BOUND_W-1:0] LAST = class_base(k + 1, TS);

        logic [TS-1:0] free_vec;
        logic [TS-1:0] first_free;

        always_comb
        begin
            for (int j = 0; j < TS; j++)
            begin
                free_vec[j] = !in_use_reg[j] && (j >= int'(BASE)) && (j < int'(LAST));
            end
        end

        // isolate the lowest free bit, then encode it
        assign first_free = free_vec & (~free_vec + TS'(1));

        always_comb
        begin
            low_comb[k] = '0;
            for (int j = 0; j < TS; j++)
            begin
                if (first_free[j])
                    low_comb[k] = low_comb[k] | SLOT_W'(j);
            end
        end

        assign any_comb[k] = |free_vec;
        assign fit_comb[k] = (size_reg <= limit_reg[k]);
        assign hit_comb[k] = ({1'b0, slot_reg} >= BASE) && ({1'b0, slot_reg} < LAST);
    end

    // first class that fits and has room, or the class covering a freed slot
    always_comb
    begin
        sel_ok    = 1'b0;
        sel_slot  = '0;
        sel_class = '0;
        if (mode_reg == MODE_ALLOC)
        begin
            for (int k = NC - 1; k >= 0; k--)
            begin
                if (fit_reg[k] && any_reg[k])
                begin
                    sel_ok    = 1'b1;
                    sel_slot  = low_reg[k];
                    sel_class = CLASS_W'(k);
                end
            end
        end
        else
        begin
            for (int k = 0; k < NC; k++)
            begin
                if (hit_reg[k])
                begin
                    sel_ok    = 1'b1;
                    sel_slot  = slot_reg;
                    sel_class = CLASS_W'(k);
                end
            end
        end
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        if (cmd.commit && sel_ok)
            in_use_next[sel_slot[IDX_W-1:0]] = (mode_reg == MODE_ALLOC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            for (int k = 0; k < MAX_CLASSES; k++)
                limit_reg[k] <= LIMIT_RESET[k];
        end
        else
        begin
            in_use_reg <= in_use_next;
            if (cfg_we)
                limit_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            size_reg <= in_size;
            slot_reg <= in_slot;
        end
        if (cmd.eval)
        begin
            fit_reg <= fit_comb;
            any_reg <= any_comb;
            hit_reg <= hit_comb;
            for (int k = 0; k < NC; k++)
                low_reg[k] <= low_comb[k];
        end
        if (cmd.commit)
        begin
            out_success <= sel_ok;
            out_slot    <= sel_slot;
            out_class   <= sel_class;
        end
    end

endmodule

// ----- design/size_class_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// size_class_slot_allocator
// buffer slot pool with eight size classes, allocate and free by request word
// ----------------------------------------------------------------------------
// usage
//   input stream s_*: one request word per handshake; s_tuser is the mode
//   (0 allocate with request_size, 1 free slot_to_free)
//   output stream m_*: exactly one result word per request; m_tuser is
//   success, m_tdata carries slot_index and size_class (both zero on failure)
//   cfg_*: write class limits only while no request is in flight
// timing
//   a request runs through capture, per-class scan and commit; the next word
//   is taken the cycle after the commit, so no word is taken while one is in flight
//   the scan stage (a compare and a lowest-free encoder per class) and the
//   commit stage (class pick and in-use update) each have a state of their own
//   the result is registered at commit, once the output register is free
// reset
//   all slots free, limits back to their defaults, no result pending
// backpressure
//   a held result stays in the output register; a new request is still taken
//   and waits in the commit state until the held word leaves
// ----------------------------------------------------------------------------
module size_class_slot_allocator
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int TOTAL_SLOTS = 160
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // request_size[19:0], slot_to_free[27:20], zero pad
    input  logic                 s_tuser,   // mode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // slot_index[7:0], size_class[10:8], zero pad
    output logic                 m_tuser,   // success
    // class limit writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    scsa_cmd_t          cmd;
    logic [SLOT_W-1:0]  res_slot;
    logic [CLASS_W-1:0] res_class;

    // sequencer and handshake owner
    scsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // pool state and scan logic
    scsa_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_mode     (s_tuser),
        .in_size     (s_tdata[19:0]),
        .in_slot     (s_tdata[27:20]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_success (m_tuser),
        .out_slot    (res_slot),
        .out_class   (res_class)
    );

    assign m_tdata = {5'd0, res_class, res_slot};

endmodule

// ----- design/scsa_chk.sv -----
// ----------------------------------------------------------------------------
// scsa_chk
// port-level checks for the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
module scsa_chk
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int TOTAL_SLOTS = 160
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [15:0]          m_tdata,
    input logic                 m_tuser
);

    // a result word is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // one request at a time: no new word right after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in flight");

    // a failed request reports zero slot and class
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("failed result carries nonzero fields");

    // a granted slot lies inside the pool and its class is below NUM_CLASSES
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (int'(m_tdata[7:0]) < TOTAL_SLOTS)
                                && (int'(m_tdata[10:8]) < NUM_CLASSES))
        else $error("result slot or class out of range");

endmodule

bind size_class_slot_allocator scsa_chk #(
    .NUM_CLASSES (NUM_CLASSES),
    .TOTAL_SLOTS (TOTAL_SLOTS)
) u_scsa_chk (.*);

// ----- dv/scsa_checker.sv -----
// ----------------------------------------------------------------------------
// scsa_checker
// tracks slot occupancy and class limits, predicts each result word and
// compares it field by field with what leaves the allocator
// ----------------------------------------------------------------------------
module scsa_checker
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int TOTAL_SLOTS = 160
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,   // request_size[19:0], slot_to_free[27:20], zero pad
    input  logic                 s_tuser,   // mode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,   // slot_index[7:0], size_class[10:8], zero pad
    input  logic                 m_tuser,   // success
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output int                   mismatches,
    output int                   pending
);

    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  slot;
        logic [CLASS_W-1:0] cls;
    } slot_grant_t;

    logic [LIMIT_W-1:0] class_limit [MAX_CLASSES];
    logic               slot_busy   [TOTAL_SLOTS];
    slot_grant_t        grants_due  [$];

    // walks the classes in order; an allocate takes the lowest free slot of the
    // first class whose limit covers the size and that has a free slot, a free clears the named slot
    function automatic slot_grant_t serve_request(input logic               mode,
                                                  input logic [LIMIT_W-1:0] size,
                                                  input logic [SLOT_W-1:0]  slot);
        slot_grant_t r;
        int          first;
        int          stop;
        r     = '0;
        first = 0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            stop = first + CLASS_COUNT[k];
            if (stop > TOTAL_SLOTS)
                stop = TOTAL_SLOTS;
            if (mode == MODE_ALLOC && !r.granted && size <= class_limit[k])
            begin
                for (int j = first; j < stop; j++)
                begin
                    if (!r.granted && !slot_busy[j])
                    begin
                        slot_busy[j] = 1'b1;
                        r.granted    = 1'b1;
                        r.slot       = SLOT_W'(j);
                        r.cls        = CLASS_W'(k);
                    end
                end
            end
            // slots past the pool end fall in no class and give a zero word
            if (mode == MODE_FREE && !r.granted && slot >= first && slot < stop)
            begin
                slot_busy[slot] = 1'b0;
                r.granted       = 1'b1;
                r.slot          = slot;
                r.cls           = CLASS_W'(k);
            end
            first = stop;
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t scsa_checker: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        slot_grant_t want;
        slot_grant_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CLASSES; k++)
                class_limit[k] = LIMIT_RESET[k];
            for (int j = 0; j < TOTAL_SLOTS; j++)
                slot_busy[j] = 1'b0;
            grants_due.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.granted = m_tuser;
                got.slot    = m_tdata[7:0];
                got.cls     = m_tdata[10:8];
                if (grants_due.size() == 0)
                begin
                    $display("%0t scsa_checker: word expected none actual %0d/%0d/%0d",
                             $time, got.granted, got.slot, got.cls);
                    mismatches++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    compare_field("success", want.granted, got.granted);
                    compare_field("slot_index", want.slot, got.slot);
                    compare_field("size_class", want.cls, got.cls);
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(serve_request(s_tuser, s_tdata[19:0], s_tdata[27:20]));
            if (cfg_we)
                class_limit[cfg_index] = cfg_data;
            pending = grants_due.size();
        end
    end

endmodule

// ----- dv/tb_size_class_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_size_class_slot_allocator
// drives allocate and free words into the slot allocator under several class
// limit settings, with random stalls on both streams; scsa_checker predicts
// every result word and counts mismatches, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_size_class_slot_allocator;
    import scsa_pkg::*;

    localparam int NUM_CLASSES = 8;
    localparam int TOTAL_SLOTS = 160;
    localparam logic [LIMIT_W-1:0] SIZE_MAX = '1;

    // how the class limits are loaded for one traffic phase
    typedef enum int {
        LIM_DEFAULT,
        LIM_ALL_MAX,
        LIM_ALL_ZERO,
        LIM_ASCENDING,
        LIM_MIXED,
        LIM_RANDOM
    } limit_plan_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // request_size[19:0], slot_to_free[27:20], zero pad
    logic                 s_tuser   = 1'b0; // mode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;          // slot_index[7:0], size_class[10:8], zero pad
    logic                 m_tuser;          // success
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_IDX_W-1:0] cfg_pick;
    logic [LIMIT_W-1:0]   cfg_data  = '0;
    int                   mismatches;
    int                   pending;

    // idle pressure knobs, percent chance that a burst starts on a given word (sender) or cycle (receiver)
    int                   tx_gap_pct   = 0;
    int                   rx_stall_pct = 0;
    int                   rx_hold      = 0;

    // limits as last written, used to aim request sizes at class edges
    logic [LIMIT_W-1:0]   limit_now [MAX_CLASSES];

    limit_plan_t plans [7] = '{LIM_ALL_MAX, LIM_ALL_ZERO, LIM_ASCENDING, LIM_RANDOM,
                               LIM_MIXED, LIM_ASCENDING, LIM_DEFAULT};

    size_class_slot_allocator #(
        .NUM_CLASSES (NUM_CLASSES),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_dut (.*);

    scsa_checker #(
        .NUM_CLASSES (NUM_CLASSES),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_checker (.*);

    always #4 clk = ~clk;

    // hard stop in case the pipeline hangs
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // result side: m_tready drops in bursts of random length at rx_stall_pct odds
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold  = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
        begin
            rx_hold  = $urandom_range(14, 1) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // one request word; valid stays high into the next call unless a gap
    // is taken, so back to back words see no bubble
    task automatic post_request(input logic               mode,
                                input logic [LIMIT_W-1:0] size,
                                input logic [SLOT_W-1:0]  slot);
        int gap;
        @(negedge clk);
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            gap = $urandom_range(14, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, slot, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and hold off until every predicted word has come out
    task automatic wait_pool_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // one result per request, so the block is idle now; a few spare cycles
        repeat (4) @(negedge clk);
    endtask

    task automatic load_limits(input limit_plan_t plan);
        logic [LIMIT_W-1:0] v [MAX_CLASSES];
        int                 acc;
        for (int k = 0; k < MAX_CLASSES; k++)
        begin
            case (plan)
                LIM_DEFAULT:  v[k] = LIMIT_RESET[k];
                LIM_ALL_MAX:  v[k] = SIZE_MAX;
                LIM_ALL_ZERO: v[k] = '0;
                LIM_ASCENDING:
                begin
                    if (k == 0)
                        acc = $urandom_range(4000);
                    else
                        acc = int'(v[k-1]) + $urandom_range(40000);
                    if (acc > int'(SIZE_MAX))
                        acc = int'(SIZE_MAX);
                    v[k] = LIMIT_W'(acc);
                end
                LIM_MIXED:
                begin
                    case ($urandom_range(2))
                        0:       v[k] = '0;
                        1:       v[k] = SIZE_MAX;
                        default: v[k] = LIMIT_W'($urandom);
                    endcase
                end
                default:      v[k] = LIMIT_W'($urandom);
            endcase
        end
        // back to back writes, one register per edge
        for (int k = 0; k < MAX_CLASSES; k++)
        begin
            @(negedge clk);
            cfg_pick     = CFG_IDX_W'(k);
            cfg_we       <= 1'b1;
            cfg_index    <= cfg_pick;
            cfg_data     <= v[k];
            limit_now[k] = v[k];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // sizes aimed at a random class: zero, exactly the limit, one past it,
    // anything up to it, or any 20-bit value
    function automatic logic [LIMIT_W-1:0] pick_size();
        int k;
        k = $urandom_range(NUM_CLASSES - 1);
        case ($urandom_range(9))
            0:       return '0;
            1:       return LIMIT_W'($urandom);
            2, 3:    return limit_now[k];
            4:       return (limit_now[k] == SIZE_MAX) ? SIZE_MAX : limit_now[k] + 1'b1;
            default: return LIMIT_W'($urandom_range(limit_now[k]));
        endcase
    endfunction

    // random words; the unused field of each word carries random bits too
    task automatic run_traffic(input int count, input int alloc_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < alloc_pct)
                post_request(MODE_ALLOC, pick_size(), SLOT_W'($urandom));
            else if ($urandom_range(9) == 0)
                post_request(MODE_FREE, LIMIT_W'($urandom),
                             SLOT_W'($urandom_range(255, TOTAL_SLOTS)));
            else
                post_request(MODE_FREE, LIMIT_W'($urandom),
                             SLOT_W'($urandom_range(TOTAL_SLOTS - 1)));
        end
    endtask

    initial
    begin : stimulus
        for (int k = 0; k < MAX_CLASSES; k++)
            limit_now[k] = LIMIT_RESET[k];
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset limits
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        post_request(MODE_ALLOC, 20'd0, 8'd0);        // smallest size, lowest slot
        post_request(MODE_ALLOC, 20'd5001, 8'd0);     // just past class 0
        post_request(MODE_ALLOC, 20'd7001, 8'd0);
        post_request(MODE_ALLOC, 20'd10001, 8'd0);
        post_request(MODE_ALLOC, 20'd30001, 8'd0);
        post_request(MODE_ALLOC, 20'd50001, 8'd0);
        post_request(MODE_ALLOC, 20'd60001, 8'd0);
        post_request(MODE_ALLOC, 20'd70001, 8'd0);
        post_request(MODE_ALLOC, 20'd102401, 8'd0);   // above every limit, no grant
        post_request(MODE_ALLOC, SIZE_MAX, 8'd0);
        // fill the largest class: nine more slots, then no room and no spill
        for (int i = 0; i < 10; i++)
            post_request(MODE_ALLOC, 20'd102400, 8'd0);
        post_request(MODE_FREE, 20'd0, 8'd0);         // release a slot in use
        post_request(MODE_FREE, 20'd0, 8'd0);         // release it again, already free
        post_request(MODE_FREE, 20'd0, 8'd159);       // last slot of the pool
        post_request(MODE_FREE, 20'd0, 8'd160);       // first slot outside the pool
        post_request(MODE_FREE, SIZE_MAX, 8'd255);    // farthest slot outside
        // hold the sender until the directed words have all come back
        wait_pool_idle();

        // random phases, each under its own limit setting; fill and drain
        // bursts alternate so classes run full and spill upward
        for (int p = 0; p < 7; p++)
        begin
            load_limits(plans[p]);
            if (p == 6)
            begin
                // no idling in the closing phase
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = (p == 1) ? 0 : $urandom_range(50, 10);
                rx_stall_pct = (p == 2) ? 0 : $urandom_range(50, 10);
            end
            for (int c = 0; c < 7; c++)
                run_traffic(40, (c % 3 == 0) ? 85 : ((c % 3 == 1) ? 25 : 60));
            wait_pool_idle();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- size_class_slot_allocator.f -----
design/scsa_pkg.sv
design/scsa_ctrl.sv
design/scsa_dp.sv
design/size_class_slot_allocator.sv
design/scsa_chk.sv
dv/scsa_checker.sv
dv/tb_size_class_slot_allocator.sv
